// ===== hw/rtl/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;

    typedef logic [31:0] t_word;

    // one entry of the queue between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_item;

    function automatic t_word round_const(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_front.sv =====
`default_nettype none
// input queue: accepts byte items, drops items that do nothing
module sha256_front #(
    parameter int unsigned Depth = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  wire  [7:0]          i_message_byte,
    input  wire                 i_byte_present,
    input  wire                 i_end_of_message,
    output logic                o_valid,
    output sha256_pkg::t_item   o_item,
    input  wire                 i_take
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

    sha256_pkg::t_item r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;
    logic          w_push, w_pop, w_useful;

    assign o_full   = (r_cnt == (Aw+1)'(Depth));
    assign o_valid  = (r_cnt != '0);
    assign o_item   = r_mem[r_rp];
    assign w_useful = i_byte_present | i_end_of_message;
    assign w_push   = i_push & ~o_full & w_useful;
    assign w_pop    = i_take & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{data: i_message_byte, present: i_byte_present,
                             last: i_end_of_message};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == Aw'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == Aw'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(w_push) - (Aw+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_back.sv =====
`default_nettype none
// block buffer, padding, 64-round compression and digest output
module sha256_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire sha256_pkg::t_item i_item,
    output logic                o_take,
    output logic                o_empty,
    input  wire                 i_pop,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_number,
    output logic                o_final_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state        r_state;
    logic [31:0]   r_blk [16];
    logic [31:0]   r_w   [16];
    logic [31:0]   r_h   [8];
    logic [31:0]   r_v   [8];
    logic [5:0]    r_fill;
    logic [60:0]   r_total;
    logic [5:0]    r_round;
    logic [2:0]    r_idx;
    logic          r_final_blk;
    logic          r_pad_done;
    logic          r_end_pend;

    logic [31:0] w_wt, w_x, w_y, w_s1, w_ch, w_t1, w_s0, w_maj;
    logic [3:0]  w_ri;
    logic [1:0]  w_lane;
    logic [63:0] w_bits;

    assign w_ri = r_round[3:0];
    assign w_x  = r_w[4'(w_ri + 4'd1)];
    assign w_y  = r_w[4'(w_ri + 4'd14)];

    always_comb begin
        if (r_round < 6'd16) begin
            w_wt = r_blk[w_ri];
        end else begin
            w_wt = r_w[w_ri] + r_w[4'(w_ri + 4'd9)]
                 + ({w_x[6:0], w_x[31:7]} ^ {w_x[17:0], w_x[31:18]} ^ (w_x >> 3))
                 + ({w_y[16:0], w_y[31:17]} ^ {w_y[18:0], w_y[31:19]}
                    ^ (w_y >> 10));
        end
        w_s1  = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
              ^ {r_v[4][24:0], r_v[4][31:25]};
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_t1  = r_v[7] + w_s1 + w_ch + sha256_pkg::round_const(r_round) + w_wt;
        w_s0  = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
              ^ {r_v[0][21:0], r_v[0][31:22]};
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    assign w_bits        = {r_total, 3'b000};
    assign w_lane        = r_fill[1:0];
    assign o_take        = (r_state == S_IDLE) & i_valid;
    assign o_empty       = (r_state != S_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_number = r_idx;
    assign o_final_word  = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_final_blk <= 1'b0;
            r_pad_done  <= 1'b0;
            r_end_pend  <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_hash(3'(i));
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_item.present) begin
                            r_blk[r_fill[5:2]][8*(3-w_lane) +: 8] <= i_item.data;
                            r_fill  <= r_fill + 6'd1;
                            r_total <= r_total + 61'd1;
                        end
                        r_pad_done <= 1'b0;
                        if (i_item.present && r_fill == 6'd63) begin
                            r_final_blk <= 1'b0;
                            r_state     <= S_LOAD;
                            // last byte of a block and end: pad after compression
                            r_end_pend  <= i_item.last;
                        end else if (i_item.last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // 0x80 at fill, then zeros byte by byte, then the length into words 14 and 15
                    if (!r_pad_done) begin
                        r_blk[r_fill[5:2]][8*(3-w_lane) +: 8] <= 8'h80;
                        r_pad_done <= 1'b1;
                        if (r_fill == 6'd63) begin
                            r_final_blk <= 1'b0;
                            r_state     <= S_LOAD;
                        end
                        r_fill <= r_fill + 6'd1;
                    end else if (r_fill < 6'd56 && r_fill != 6'd0) begin
                        r_blk[r_fill[5:2]][8*(3-w_lane) +: 8] <= 8'h00;
                        r_fill <= r_fill + 6'd1;
                    end else if (r_fill > 6'd56) begin
                        r_blk[r_fill[5:2]][8*(3-w_lane) +: 8] <= 8'h00;
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_final_blk <= 1'b0;
                            r_state     <= S_LOAD;
                        end
                    end else begin
                        // fill is 56, or 0 after an extra block
                        for (int i = 0; i < 14; i++) begin
                            if (r_fill == 6'd0) r_blk[i] <= '0;
                        end
                        r_blk[14]   <= w_bits[63:32];
                        r_blk[15]   <= w_bits[31:0];
                        r_final_blk <= 1'b1;
                        r_state     <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_w[w_ri] <= w_wt;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_s0 + w_maj;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_fill <= '0;
                    if (r_final_blk) begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end else if (r_pad_done || r_end_pend) begin
                        r_end_pend <= 1'b0;
                        r_state    <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state     <= S_IDLE;
                            r_fill      <= '0;
                            r_total     <= '0;
                            r_final_blk <= 1'b0;
                            r_pad_done  <= 1'b0;
                            r_end_pend  <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha256_pkg::init_hash(3'(i));
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_message_digest_top.sv =====
`default_nettype none
// SHA-256 over a byte stream. The back end takes byte items only while idle;
// a 64-byte block then goes through load, 64 rounds at one per cycle and hash
// add, and an ending item pads the block up to the length field before the
// final one or two compressions; the eight digest words then come out one per
// pop. The input queue (QueueDepth items) keeps taking bytes while a block
// compresses. State returns to its initial values after word 7 is popped.
module sha256_message_digest_top #(
    parameter int unsigned QueueDepth = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_message_byte,
    input  wire         i_byte_present,
    input  wire         i_end_of_message,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_final_word
);
    logic              w_valid, w_take;
    sha256_pkg::t_item w_item;

    sha256_front #(.Depth(QueueDepth)) u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full),
        .i_message_byte, .i_byte_present, .i_end_of_message,
        .o_valid(w_valid), .o_item(w_item), .i_take(w_take)
    );

    sha256_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_valid), .i_item(w_item), .o_take(w_take),
        .o_empty(empty), .i_pop(pop),
        .o_digest_word, .o_word_number, .o_final_word
    );
endmodule
`default_nettype wire

// ===== verif/tb_sha256_message_digest_top.sv =====
`timescale 1ns / 100ps
module tb_sha256_message_digest_top;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  num;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_message_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_final_word;

    sha256_message_digest_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_message_byte(i_message_byte), .i_byte_present(i_byte_present),
        .i_end_of_message(i_end_of_message), .empty(empty), .pop(pop),
        .o_digest_word(o_digest_word), .o_word_number(o_word_number),
        .o_final_word(o_final_word)
    );

    always #1 i_clk = ~i_clk;

    localparam logic [31:0] HashIv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // digest state of the predictor
    logic [31:0] hash_acc [8];
    logic [7:0]  blk [64];
    logic [5:0]  blk_fill;
    logic [60:0] msg_len;

    sha256_pkg::t_item msg_items [$];
    t_digest_word      digest_q [$];
    int                mismatches = 0;
    bit                quiet = 1'b0;
    longint            cycles = 0;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic hash_reset();
        hash_acc = HashIv;
        blk_fill = '0;
        msg_len  = '0;
    endtask

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            end else begin
                w[t] = w[t-16] + w[t-7]
                     + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                     + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
            end
        end
        {a, b, c, d, e, f, g, h} = {hash_acc[0], hash_acc[1], hash_acc[2], hash_acc[3],
                                    hash_acc[4], hash_acc[5], hash_acc[6], hash_acc[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + RoundK[t] + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
        hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
    endtask

    task automatic digest_accept(input sha256_pkg::t_item it);
        logic [63:0] bits;
        int          pos;
        if (it.present) begin
            blk[blk_fill] = it.data;
            msg_len++;
            blk_fill++;
            if (blk_fill == 0) compress();
        end
        if (!it.last) return;
        pos = blk_fill;
        blk[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
            for (int i = pos; i < 64; i++) blk[i] = '0;
            compress();
            pos = 0;
        end
        for (int i = pos; i < 56; i++) blk[i] = '0;
        bits = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
            digest_q.push_back('{hash_acc[i], 3'(i), i == 7});
        end
        hash_reset();
    endtask

    task automatic add_message(input int len, input bit end_only);
        for (int i = 0; i < len; i++) begin
            msg_items.push_back('{8'($urandom_range(0, 255)), 1'b1,
                                  (i == len - 1) && !end_only});
        end
        if (end_only || len == 0) msg_items.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    // driver
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                digest_accept('{i_message_byte, i_byte_present, i_end_of_message});
                void'(msg_items.pop_front());
            end
            if (!(push && full)) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    push <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    drv_gap = $urandom_range(1, 13) - 1;
                    push <= 1'b0;
                end else if (msg_items.size() > 0) begin
                    sha256_pkg::t_item nx;
                    nx = msg_items[0];
                    push             <= 1'b1;
                    i_message_byte   <= nx.data;
                    i_byte_present   <= nx.present;
                    i_end_of_message <= nx.last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    int mon_gap = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (digest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h num %0d", o_digest_word, o_word_number);
                end else begin
                    t_digest_word ex;
                    ex = digest_q.pop_front();
                    if (ex.word !== o_digest_word || ex.num !== o_word_number
                            || ex.last !== o_final_word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     ex.word, ex.num, ex.last,
                                     o_digest_word, o_word_number, o_final_word);
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                mon_gap = $urandom_range(1, 13) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
        if (cycles > 400000) begin
            $display("FAIL sha256_message_digest_top");
            $finish;
        end
    end

    initial begin
        hash_reset();
        // directed: empty message, idle item, byte+end, short message
        add_message(0, 1'b1);
        msg_items.push_back('{8'hff, 1'b0, 1'b0});
        msg_items.push_back('{8'h00, 1'b1, 1'b1});
        msg_items.push_back('{8'hff, 1'b1, 1'b1});
        add_message(3, 1'b1);
        // last byte of a full block carries the end
        add_message(64, 1'b0);
        // 0x80 lands at 56, length needs an extra block
        add_message(56, 1'b0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (msg_items.size() > 60) @(posedge i_clk);
        quiet = 1'b1;
        while (msg_items.size() > 0 || digest_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && digest_q.size() == 0) begin
            $display("PASS sha256_message_digest_top");
        end else begin
            $display("FAIL sha256_message_digest_top");
        end
        $finish;
    end
endmodule
